FILE: design/xrs_pkg.sv
// xrs_pkg: shared types and constants for the xoshiro256++ random source.
// Request/response payloads, reseed phase codes, controller command/status.
// No dependencies.
package xrs_pkg;

   localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

   localparam int unsigned SM_SH1     = 30;
   localparam int unsigned SM_SH2     = 27;
   localparam int unsigned SM_SH3     = 31;
   localparam int unsigned XO_SHIFT   = 17;
   localparam int unsigned FRAC_SHIFT = 11;
   localparam int unsigned FRAC_W     = 64 - FRAC_SHIFT;

   localparam logic ACT_RESEED = 1'b0;
   localparam logic ACT_DRAW   = 1'b1;

   typedef struct packed {
      logic        action;
      logic [63:0] seed;
   } req_type;

   typedef struct packed {
      logic              drew;
      logic [63:0]       value;
      logic [FRAC_W-1:0] fraction;
   } rsp_type;

   // splitmix64 steps for one generator word
   typedef enum logic [3:0] {
      PH_ADD,
      PH_M1A,
      PH_M1B,
      PH_M1C,
      PH_X2,
      PH_M2A,
      PH_M2B,
      PH_M2C,
      PH_STORE
   } phase_type;

   typedef struct packed {
      logic      load_out;
      logic      draw;
      logic      load_seed;
      logic      zero_seed;
      logic      run;
      phase_type phase;
      logic [1:0] word;
   } cmd_type;

   typedef struct packed {
      logic rsp_full;
   } sts_type;

   // 64-bit rotates by fixed amounts
   function automatic logic [63:0] rotl23(input logic [63:0] v);
      return {v[40:0], v[63:41]};
   endfunction

   function automatic logic [63:0] rotl45(input logic [63:0] v);
      return {v[18:0], v[63:19]};
   endfunction

endpackage

FILE: design/xrs_ctrl.sv
// xrs_ctrl: controller for the random source.
// Sequences the reseed (splitmix64) steps and gates request acceptance.
// Depends on xrs_pkg.
module xrs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   input  logic              rsp_stall,
   input  xrs_pkg::sts_type  sts,
   output logic              req_stall,
   output xrs_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_BOOT,
      ST_IDLE,
      ST_MIX
   } state_type;

   state_type          state_ff, state_in;
   xrs_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         word_ff, word_in;
   logic               ready;
   logic               accept;

   always_comb begin
      ready     = (state_ff == ST_IDLE) && (!sts.rsp_full || !rsp_stall);
      accept    = req_valid && ready;
      req_stall = !ready;

      cmd.load_out  = accept;
      cmd.draw      = accept && (req_action == xrs_pkg::ACT_DRAW);
      cmd.load_seed = (accept && (req_action == xrs_pkg::ACT_RESEED)) ||
                      (state_ff == ST_BOOT);
      cmd.zero_seed = (state_ff == ST_BOOT);
      cmd.run       = (state_ff == ST_MIX);
      cmd.phase     = phase_ff;
      cmd.word      = word_ff;

      state_in = state_ff;
      phase_in = phase_ff;
      word_in  = word_ff;
      unique case (state_ff)
         ST_BOOT: begin
            state_in = ST_MIX;
            phase_in = xrs_pkg::PH_ADD;
            word_in  = 2'd0;
         end
         ST_IDLE: begin
            if (accept && (req_action == xrs_pkg::ACT_RESEED)) begin
               state_in = ST_MIX;
               phase_in = xrs_pkg::PH_ADD;
               word_in  = 2'd0;
            end
         end
         ST_MIX: begin
            if (phase_ff == xrs_pkg::PH_STORE) begin
               phase_in = xrs_pkg::PH_ADD;
               word_in  = word_ff + 2'd1;
               if (word_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end else begin
               phase_in = xrs_pkg::phase_type'(phase_ff + 4'd1);
            end
         end
         default: state_in = ST_BOOT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         phase_ff <= xrs_pkg::PH_ADD;
         word_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         word_ff  <= word_in;
      end
   end

endmodule

FILE: design/xrs_dp.sv
// xrs_dp: datapath for the random source.
// Generator words, xoshiro256++ draw logic, splitmix64 mixer with a shared
// 32x32 multiplier, and the response register. Depends on xrs_pkg.
module xrs_dp (
   input  logic              clock,
   input  logic              reset,
   input  xrs_pkg::cmd_type  cmd,
   input  logic [63:0]       req_seed,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output xrs_pkg::rsp_type  rsp_payload,
   output xrs_pkg::sts_type  sts
);

   logic [63:0]      words_ff [4];
   logic [63:0]      ctr_ff, ctr_in;
   logic [63:0]      z_ff, z_in;
   logic [63:0]      acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   xrs_pkg::rsp_type rsp_ff, rsp_in;

   logic [63:0] draw_out;
   logic [63:0] t2, t3;
   logic [63:0] n0, n1, n2, n3;
   logic [63:0] gamma_sum;
   logic [63:0] mconst;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] mixed;

   // xoshiro256++ output and next state
   always_comb begin
      draw_out = xrs_pkg::rotl23(words_ff[0] + words_ff[3]) + words_ff[0];
      t2 = words_ff[2] ^ words_ff[0];
      t3 = words_ff[3] ^ words_ff[1];
      n0 = words_ff[0] ^ t3;
      n1 = words_ff[1] ^ t2;
      n2 = t2 ^ (words_ff[1] << xrs_pkg::XO_SHIFT);
      n3 = xrs_pkg::rotl45(t3);
   end

   // splitmix64 step logic
   always_comb begin
      gamma_sum = ctr_ff + xrs_pkg::SM_GAMMA;
      mixed     = acc_ff ^ (acc_ff >> xrs_pkg::SM_SH3);

      case (cmd.phase) inside
         xrs_pkg::PH_M2A, xrs_pkg::PH_M2B, xrs_pkg::PH_M2C: mconst = xrs_pkg::SM_MUL2;
         default:                                           mconst = xrs_pkg::SM_MUL1;
      endcase

      case (cmd.phase) inside
         xrs_pkg::PH_M1B, xrs_pkg::PH_M2B: begin
            mul_a = z_ff[31:0];
            mul_b = mconst[63:32];
         end
         xrs_pkg::PH_M1C, xrs_pkg::PH_M2C: begin
            mul_a = z_ff[63:32];
            mul_b = mconst[31:0];
         end
         default: begin
            mul_a = z_ff[31:0];
            mul_b = mconst[31:0];
         end
      endcase
      prod = {32'd0, mul_a} * {32'd0, mul_b};

      ctr_in = ctr_ff;
      z_in   = z_ff;
      acc_in = acc_ff;
      if (cmd.load_seed) begin
         ctr_in = cmd.zero_seed ? 64'd0 : req_seed;
      end else if (cmd.run) begin
         case (cmd.phase) inside
            xrs_pkg::PH_ADD: begin
               ctr_in = gamma_sum;
               z_in   = gamma_sum ^ (gamma_sum >> xrs_pkg::SM_SH1);
            end
            xrs_pkg::PH_M1A, xrs_pkg::PH_M2A: acc_in = prod;
            xrs_pkg::PH_M1B, xrs_pkg::PH_M2B, xrs_pkg::PH_M1C, xrs_pkg::PH_M2C: begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
            end
            xrs_pkg::PH_X2: z_in = acc_ff ^ (acc_ff >> xrs_pkg::SM_SH2);
            default: ;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.load_out) begin
         rsp_valid_in    = 1'b1;
         rsp_in.drew     = cmd.draw;
         rsp_in.value    = cmd.draw ? draw_out : 64'd0;
         rsp_in.fraction = cmd.draw ? draw_out[63:xrs_pkg::FRAC_SHIFT] : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      ctr_ff <= ctr_in;
      z_ff   <= z_in;
      acc_ff <= acc_in;
      if (cmd.draw) begin
         words_ff[0] <= n0;
         words_ff[1] <= n1;
         words_ff[2] <= n2;
         words_ff[3] <= n3;
      end else if (cmd.run && (cmd.phase == xrs_pkg::PH_STORE)) begin
         words_ff[cmd.word] <= mixed;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;
   assign sts.rsp_full = rsp_valid_ff;

endmodule

FILE: design/xoshiro256pp_random_source.sv
// xoshiro256++ random source: one response per request, from a response register.
// The response is registered: rsp_valid rises in the cycle after the request is taken.
// Draws: one per cycle unless a held response is stalled. Reseed: the four-word
// splitmix64 fill runs 9 steps per word on a shared 32x32 multiplier; requests stall
// until it ends. Reset: the same fill with seed 0 runs first; requests stall meanwhile.
// Depends on xrs_pkg, xrs_ctrl, xrs_dp.
module xoshiro256pp_random_source (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  xrs_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xrs_pkg::rsp_type  rsp_payload
);

   xrs_pkg::cmd_type cmd;
   xrs_pkg::sts_type sts;

   xrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   xrs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_seed    (req_payload.seed),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .sts         (sts)
   );

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.run |-> req_stall)
      else $error("request taken during reseed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
      else $error("request taken while response held");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no response after request");

   a_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.fraction == rsp_payload.value[63:11]))
      else $error("fraction does not match value");

endmodule

FILE: tb/xoshiro256pp_random_source_tb.sv
// Self-checking testbench for xoshiro256pp_random_source: directed table, then random
// reseed/draw requests under three handshake pressure settings, checked by a local model.
// Depends on xrs_pkg and the xoshiro256pp_random_source RTL.
`timescale 1ns / 1ps

module xoshiro256pp_random_source_tb;

   localparam int unsigned ROT_OUT    = 23;
   localparam int unsigned ROT_STATE  = 45;
   localparam int unsigned ITEMS_PER_PHASE = 184;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES = 48;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned DIR_ROWS = 18;
   localparam xrs_pkg::rsp_type RESEED_ACK = '0;

   typedef struct packed {
      logic             action;
      logic [63:0]      seed;
      logic             known;
      xrs_pkg::rsp_type want;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   xrs_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   xrs_pkg::rsp_type rsp_payload;

   logic             cur_known;
   xrs_pkg::rsp_type cur_want;
   logic [63:0]      gen_state [4];
   xrs_pkg::rsp_type pending_rsp [$];
   stim_row_type     dir_rows [DIR_ROWS];

   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned quiet_cycles;
   int unsigned error_count;
   int unsigned draw_count;
   int unsigned reseed_count;

   xoshiro256pp_random_source uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] rot64(input logic [63:0] v, input int unsigned k);
      return (v << k) | (v >> (64 - k));
   endfunction

   function automatic logic [63:0] splitmix_out(input logic [63:0] ctr);
      logic [63:0] z;
      z = ctr;
      z = (z ^ (z >> xrs_pkg::SM_SH1)) * xrs_pkg::SM_MUL1;
      z = (z ^ (z >> xrs_pkg::SM_SH2)) * xrs_pkg::SM_MUL2;
      return z ^ (z >> xrs_pkg::SM_SH3);
   endfunction

   function automatic void load_state(input logic [63:0] seed);
      logic [63:0] ctr;
      ctr = seed;
      for (int w = 0; w < 4; w++) begin
         ctr = ctr + xrs_pkg::SM_GAMMA;
         gen_state[w] = splitmix_out(ctr);
      end
   endfunction

   function automatic xrs_pkg::rsp_type predict_rsp(input xrs_pkg::req_type r);
      xrs_pkg::rsp_type res;
      logic [63:0]      v;
      logic [63:0]      spill;
      res = '0;
      if (r.action == xrs_pkg::ACT_RESEED) begin
         load_state(r.seed);
      end else begin
         v = rot64(gen_state[0] + gen_state[3], ROT_OUT) + gen_state[0];
         spill = gen_state[1] << xrs_pkg::XO_SHIFT;
         gen_state[2] ^= gen_state[0];
         gen_state[3] ^= gen_state[1];
         gen_state[1] ^= gen_state[2];
         gen_state[0] ^= gen_state[3];
         gen_state[2] ^= spill;
         gen_state[3] = rot64(gen_state[3], ROT_STATE);
         res.drew = 1'b1;
         res.value = v;
         res.fraction = v[63:xrs_pkg::FRAC_SHIFT];
      end
      return res;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_req(input logic act, input logic [63:0] sd, input logic known,
                           input xrs_pkg::rsp_type want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.action = act;
      req_payload.seed = sd;
      cur_known = known;
      cur_want = want;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      logic        act;
      logic [63:0] sd;
      for (int i = 0; i < count; i++) begin
         act = ($urandom_range(99) < 8) ? xrs_pkg::ACT_RESEED : xrs_pkg::ACT_DRAW;
         case ($urandom_range(7))
            0: sd = '0;
            1: sd = '1;
            2: sd = 64'd1 << $urandom_range(63);
            default: sd = {$urandom, $urandom};
         endcase
         send_req(act, sd, 1'b0, RESEED_ACK);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin : scoreboard
      xrs_pkg::rsp_type want;
      logic             progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_rsp(req_payload);
            pending_rsp = {pending_rsp, (cur_known ? cur_want : want)};
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (pending_rsp.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR: response with none pending: drew=%0b value=%h",
                           rsp_payload.drew, rsp_payload.value);
            end else begin
               want = pending_rsp.pop_front();
               if (want.drew) draw_count++;
               else reseed_count++;
               if (rsp_payload.drew !== want.drew || rsp_payload.value !== want.value ||
                   rsp_payload.fraction !== want.fraction) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"ERROR: drew exp %0b got %0b, value exp %h got %h, ",
                               "fraction exp %h got %h"},
                              want.drew, rsp_payload.drew, want.value, rsp_payload.value,
                              want.fraction, rsp_payload.fraction);
               end
            end
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      cur_known = 1'b0;
      cur_want = '0;
      req_idle_pct = 26;
      rsp_idle_pct = 87;
      quiet_cycles = 0;
      error_count = 0;
      draw_count = 0;
      reseed_count = 0;
      load_state('0);

      dir_rows = '{
         '{xrs_pkg::ACT_DRAW,   64'h0000_0000_0000_0000, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'hffff_ffff_ffff_ffff, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h5555_5555_5555_5555, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_RESEED, 64'h0000_0000_0000_0000, 1'b1, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h0000_0000_0000_0000, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_RESEED, 64'hffff_ffff_ffff_ffff, 1'b1, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h0000_0000_0000_0000, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'hffff_ffff_ffff_ffff, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_RESEED, 64'h0000_0000_0000_0001, 1'b1, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'haaaa_aaaa_aaaa_aaaa, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_RESEED, 64'h8000_0000_0000_0000, 1'b1, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h0000_0000_0000_0000, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_RESEED, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h5555_5555_5555_5555, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h0000_0000_0000_0000, 1'b0, RESEED_ACK},
         // counter wraps to zero on the first splitmix step
         '{xrs_pkg::ACT_RESEED, 64'h61c8_8646_80b5_83eb, 1'b1, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'h0000_0000_0000_0000, 1'b0, RESEED_ACK},
         '{xrs_pkg::ACT_DRAW,   64'hffff_ffff_ffff_ffff, 1'b0, RESEED_ACK}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].action, dir_rows[i].seed, dir_rows[i].known, dir_rows[i].want);
      send_random(ITEMS_PER_PHASE);

      req_idle_pct = 87;
      rsp_idle_pct = 26;
      send_random(ITEMS_PER_PHASE);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(ITEMS_PER_PHASE);

      req_valid = 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d draws and %0d reseed acks across three stall mixes, %0d errors",
               draw_count, reseed_count, error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: sim.f
design/xrs_pkg.sv
design/xrs_ctrl.sv
design/xrs_dp.sv
design/xoshiro256pp_random_source.sv
tb/xoshiro256pp_random_source_tb.sv
